// ===== rtl/tsc_pkg.sv =====
// Types and constants shared by the thermal safety command controller.
package tsc_pkg;

    // Item opcodes
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_EVAL = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_TEMP_LIMIT = 2'd0;
    localparam logic [1:0] REG_HOST_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_TELEM_PERIOD = 2'd2;

    // Register reset values
    localparam logic signed [11:0] TEMP_LIMIT_RST = 12'sd512;
    localparam logic [15:0] HOST_TIMEOUT_RST = 16'd5000;
    localparam logic [15:0] TELEM_PERIOD_RST = 16'd500;

    // Fixed values
    localparam logic [6:0] FAN_MAX = 7'd100;
    localparam logic signed [11:0] FAIL_TEMP = -12'sd2032;
    localparam logic [15:0] MS_SAT = 16'hFFFF;
    localparam logic [7:0] ACC_SAT = 8'd255;

    // Characters
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_VT = 8'd11;
    localparam logic [7:0] CH_FF = 8'd12;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         rx_byte;
        logic signed [11:0] temp_sample;
        logic               sensor_valid;
    } item_t;

    typedef struct packed {
        logic [6:0]         fan_percent;
        logic               heater_drive;
        logic               safety_tripped;
        logic signed [11:0] reported_temp;
        logic               telemetry_due;
        logic [31:0]        sequence_res;
    } result_t;

    typedef struct packed {
        logic [1:0]  addr;
        logic [15:0] data;
    } cfg_t;

endpackage

// ===== rtl/tsc_stream_if.sv =====
// Valid/ready channel carrying one payload per transaction.
interface tsc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/thermal_safety_command_controller_top.sv =====
// Thermal safety command controller: line parser, idle timers and safety evaluation.
//
//  channel | dir | payload   | transaction
//  --------+-----+-----------+------------------------------------------------
//  item    | in  | item_t    | serial byte, millisecond tick or evaluate
//  result  | out | result_t  | one per evaluate, applied drive and telemetry
//  cfg     | in  | cfg_t     | register write, addr selects the register
//
//  One item per cycle. Each item updates the state at its accepting edge; an
//  evaluate result sits in the output register from the next cycle on.
//  The item channel stalls only while that register is full and not taken.
//  rst_n clears all state asynchronously and loads the register defaults.
//  cfg is always ready; writes are expected only while the block is idle.
module thermal_safety_command_controller_top
    import tsc_pkg::*;
#(
    parameter int LINE_MAX = 32
) (
    input  logic clk,
    input  logic rst_n,
    tsc_stream_if.sink   item,
    tsc_stream_if.source result,
    tsc_stream_if.sink   cfg
);

    localparam int LCW = $clog2(LINE_MAX + 1);

    typedef enum logic [2:0] {
        PH_START,
        PH_LETTER,
        PH_PRE,
        PH_DIGITS,
        PH_DONE,
        PH_IGNORE
    } phase_t;

    // Configuration registers
    logic signed [11:0] temp_limit_reg;
    logic [15:0]        host_timeout_reg;
    logic [15:0]        telem_period_reg;

    // Controller state
    logic [6:0]     wanted_fan_reg, wanted_fan_next;
    logic           wanted_heater_reg, wanted_heater_next;
    logic [LCW-1:0] line_count_reg, line_count_next;
    phase_t         phase_reg, phase_next;
    logic [7:0]     accum_reg, accum_next;
    logic           negative_reg, negative_next;
    logic           cmd_heater_reg, cmd_heater_next;
    logic [15:0]    host_idle_reg, host_idle_next;
    logic [15:0]    telem_ms_reg, telem_ms_next;
    logic [31:0]    seq_reg, seq_next;
    result_t        res_reg, res_next;
    logic           res_valid_reg, res_valid_next;

    logic        item_acc;
    logic        cfg_acc;
    item_t       it;
    logic        is_digit;
    logic        is_blank;
    logic [11:0] mac;
    logic [7:0]  accum_digit;
    logic        trip;

    assign it = item.payload;
    assign item.ready = !res_valid_reg || result.ready;
    assign item_acc = item.valid && item.ready;
    assign cfg.ready = 1'b1;
    assign cfg_acc = cfg.valid && cfg.ready;
    assign result.valid = res_valid_reg;
    assign result.payload = res_reg;

    // Character classes and saturating decimal accumulate
    assign is_digit = (it.rx_byte >= CH_ZERO) && (it.rx_byte <= CH_NINE);
    assign is_blank = (it.rx_byte == CH_SPACE) || (it.rx_byte == CH_TAB) ||
                      (it.rx_byte == CH_VT) || (it.rx_byte == CH_FF);
    assign mac = ({4'd0, accum_reg} << 3) + ({4'd0, accum_reg} << 1) +
                 {8'd0, it.rx_byte[3:0]};
    assign accum_digit = (mac > {4'd0, ACC_SAT}) ? ACC_SAT : mac[7:0];

    // Safety decision
    assign trip = !it.sensor_valid || (it.temp_sample >= temp_limit_reg);

    // Next-state logic
    always_comb
    begin
        wanted_fan_next    = wanted_fan_reg;
        wanted_heater_next = wanted_heater_reg;
        line_count_next    = line_count_reg;
        phase_next         = phase_reg;
        accum_next         = accum_reg;
        negative_next      = negative_reg;
        cmd_heater_next    = cmd_heater_reg;
        host_idle_next     = host_idle_reg;
        telem_ms_next      = telem_ms_reg;
        seq_next           = seq_reg;
        res_next           = res_reg;
        res_valid_next     = res_valid_reg && !result.ready;

        if (item_acc)
        begin
            unique case (it.opcode)
                OP_BYTE:
                begin
                    if (it.rx_byte == CH_LF || it.rx_byte == CH_CR)
                    begin
                        // End of line: apply a parsed command, drop empty lines
                        if (line_count_reg != '0)
                        begin
                            host_idle_next = '0;
                            if (phase_reg == PH_PRE || phase_reg == PH_DIGITS ||
                                phase_reg == PH_DONE)
                            begin
                                if (cmd_heater_reg)
                                    wanted_heater_next = (accum_reg != '0);
                                else if (negative_reg)
                                    wanted_fan_next = '0;
                                else if (accum_reg > {1'b0, FAN_MAX})
                                    wanted_fan_next = FAN_MAX;
                                else
                                    wanted_fan_next = accum_reg[6:0];
                            end
                            line_count_next = '0;
                            phase_next      = PH_START;
                            accum_next      = '0;
                            negative_next   = 1'b0;
                            cmd_heater_next = 1'b0;
                        end
                    end
                    else if (line_count_reg >= LCW'(LINE_MAX))
                    begin
                        // Overlong line is discarded
                        line_count_next = '0;
                        phase_next      = PH_START;
                        accum_next      = '0;
                        negative_next   = 1'b0;
                        cmd_heater_next = 1'b0;
                    end
                    else
                    begin
                        line_count_next = line_count_reg + LCW'(1);
                        unique case (phase_reg)
                            PH_START:
                            begin
                                if (it.rx_byte == CH_F)
                                begin
                                    cmd_heater_next = 1'b0;
                                    phase_next      = PH_LETTER;
                                end
                                else if (it.rx_byte == CH_H)
                                begin
                                    cmd_heater_next = 1'b1;
                                    phase_next      = PH_LETTER;
                                end
                                else
                                    phase_next = PH_IGNORE;
                            end
                            PH_LETTER:
                                phase_next = (it.rx_byte == CH_COLON) ? PH_PRE : PH_IGNORE;
                            PH_PRE:
                            begin
                                if (is_blank)
                                    phase_next = PH_PRE;
                                else if (it.rx_byte == CH_MINUS)
                                begin
                                    negative_next = 1'b1;
                                    phase_next    = PH_DIGITS;
                                end
                                else if (it.rx_byte == CH_PLUS)
                                    phase_next = PH_DIGITS;
                                else if (is_digit)
                                begin
                                    accum_next = accum_digit;
                                    phase_next = PH_DIGITS;
                                end
                                else
                                    phase_next = PH_DONE;
                            end
                            PH_DIGITS:
                            begin
                                if (is_digit)
                                    accum_next = accum_digit;
                                else
                                    phase_next = PH_DONE;
                            end
                            default:
                                phase_next = phase_reg;
                        endcase
                    end
                end
                OP_TICK:
                begin
                    // Saturating millisecond counters
                    if (host_idle_reg != MS_SAT)
                        host_idle_next = host_idle_reg + 16'd1;
                    if (telem_ms_reg != MS_SAT)
                        telem_ms_next = telem_ms_reg + 16'd1;
                end
                OP_EVAL:
                begin
                    res_valid_next         = 1'b1;
                    res_next.fan_percent   = trip ? FAN_MAX : wanted_fan_reg;
                    res_next.heater_drive  = wanted_heater_reg && !trip &&
                                             !(host_idle_reg > host_timeout_reg);
                    res_next.safety_tripped = trip;
                    res_next.reported_temp = it.sensor_valid ? it.temp_sample : FAIL_TEMP;
                    res_next.telemetry_due = 1'b0;
                    res_next.sequence_res  = '0;
                    if (telem_ms_reg >= telem_period_reg)
                    begin
                        res_next.telemetry_due = 1'b1;
                        res_next.sequence_res  = seq_reg;
                        seq_next               = seq_reg + 32'd1;
                        telem_ms_next          = '0;
                    end
                end
                default:
                    res_valid_next = res_valid_reg && !result.ready;
            endcase
        end
    end

    // State and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_fan_reg    <= '0;
            wanted_heater_reg <= 1'b0;
            line_count_reg    <= '0;
            phase_reg         <= PH_START;
            accum_reg         <= '0;
            negative_reg      <= 1'b0;
            cmd_heater_reg    <= 1'b0;
            host_idle_reg     <= '0;
            telem_ms_reg      <= '0;
            seq_reg           <= '0;
            res_reg           <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            wanted_fan_reg    <= wanted_fan_next;
            wanted_heater_reg <= wanted_heater_next;
            line_count_reg    <= line_count_next;
            phase_reg         <= phase_next;
            accum_reg         <= accum_next;
            negative_reg      <= negative_next;
            cmd_heater_reg    <= cmd_heater_next;
            host_idle_reg     <= host_idle_next;
            telem_ms_reg      <= telem_ms_next;
            seq_reg           <= seq_next;
            res_reg           <= res_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_limit_reg   <= TEMP_LIMIT_RST;
            host_timeout_reg <= HOST_TIMEOUT_RST;
            telem_period_reg <= TELEM_PERIOD_RST;
        end
        else if (cfg_acc)
        begin
            unique case (cfg.payload.addr)
                REG_TEMP_LIMIT:   temp_limit_reg   <= cfg.payload.data[11:0];
                REG_HOST_TIMEOUT: host_timeout_reg <= cfg.payload.data;
                REG_TELEM_PERIOD: telem_period_reg <= cfg.payload.data;
                default:          temp_limit_reg   <= temp_limit_reg;
            endcase
        end
    end

    // Assertions
    a_eval_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc && it.opcode == OP_EVAL |=> result.valid)
        else $error("evaluate transaction produced no result");

    a_trip_forces_cutoff: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.payload.safety_tripped |->
            result.payload.fan_percent == FAN_MAX && !result.payload.heater_drive)
        else $error("tripped result without heater cutoff and full fan");

    a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_count_reg <= LCW'(LINE_MAX))
        else $error("line count beyond line limit");

    a_seq_only_when_due: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.payload.telemetry_due |->
            result.payload.sequence_res == '0)
        else $error("sequence number set without telemetry due");

endmodule
